### rtl/bsp_pkg.sv
`default_nettype none
package bsp_pkg;

  localparam int PT_AW = 10;
  localparam int SEG_AW = 10;
  localparam int BANK_AW = PT_AW - 2;
  localparam int PARAM_BITS = 16;
  localparam int PT_W = 128;

  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_SEG = 2'd1;
  localparam logic [1:0] REQ_EVAL = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [1:0] COMP_R = 2'd3;

  localparam logic [35:0] DIV3_MUL = 36'hA_AAAA_AAAB;
  localparam logic signed [53:0] DIV_OFS = 54'sh3_0000_0000;
  localparam logic [39:0] DIV_UNOFS = 40'h01_0000_0000;

  typedef struct packed {
    logic valid;
    logic [1:0] blo;
    logic [PARAM_BITS-1:0] t;
    logic [PARAM_BITS-1:0] v2;
    logic [PARAM_BITS-1:0] v3;
    logic [3:0][PT_W-1:0] bank;
  } eval_t;

endpackage
`default_nettype wire

### rtl/bsp_front.sv
`default_nettype none
module bsp_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic req_valid,
  input  wire logic [1:0] req_type,
  input  wire logic [bsp_pkg::PT_AW-1:0] point_index,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] radius_in,
  input  wire logic [bsp_pkg::SEG_AW-1:0] seg_sel,
  input  wire logic [bsp_pkg::PT_AW-1:0] first_point,
  input  wire logic [bsp_pkg::PARAM_BITS-1:0] v_local,
  output bsp_pkg::eval_t ev
);
  import bsp_pkg::*;

  logic s1_valid;
  logic [1:0] s1_req;
  logic [PT_AW-1:0] s1_pidx;
  logic [PT_W-1:0] s1_pos;
  logic [SEG_AW-1:0] s1_seg;
  logic [PT_AW-1:0] s1_first;
  logic [PARAM_BITS-1:0] s1_t;

  logic [PT_AW-1:0] seg_mem [2**SEG_AW];
  logic [PT_AW-1:0] base;

  logic s2_valid;
  logic [1:0] s2_req;
  logic [PT_AW-1:0] s2_pidx;
  logic [PT_W-1:0] s2_pos;
  logic [PARAM_BITS-1:0] s2_t;
  logic [PARAM_BITS-1:0] s2_v2;
  logic [2*PARAM_BITS-1:0] sq;

  logic s3_valid;
  logic [1:0] s3_blo;
  logic [PARAM_BITS-1:0] s3_t;
  logic [PARAM_BITS-1:0] s3_v2;
  logic [PARAM_BITS-1:0] s3_v3;
  logic [2*PARAM_BITS-1:0] cube;
  logic [3:0][PT_W-1:0] rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid && (req_type != REQ_NONE);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && (s2_req == REQ_EVAL);
    end
  end

  assign sq = s1_t * s1_t;
  assign cube = s2_v2 * s2_t;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req <= req_type;
      s1_pidx <= point_index;
      s1_pos <= {radius_in, pos_z, pos_y, pos_x};
      s1_seg <= seg_sel;
      s1_first <= first_point;
      s1_t <= v_local;
      s2_req <= s1_req;
      s2_pidx <= s1_pidx;
      s2_pos <= s1_pos;
      s2_t <= s1_t;
      s2_v2 <= sq[2*PARAM_BITS-1:PARAM_BITS];
      s3_blo <= base[1:0];
      s3_t <= s2_t;
      s3_v2 <= s2_v2;
      s3_v3 <= cube[2*PARAM_BITS-1:PARAM_BITS];
    end
  end

  // segment table
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid && (s1_req == REQ_SEG)) begin
        seg_mem[s1_seg] <= s1_first;
      end
      base <= seg_mem[s1_seg];
    end
  end

  // point store, four banks by index low bits
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PT_W-1:0] mem [2**BANK_AW];
    logic [1:0] off;
    logic [PT_AW-1:0] idx;
    assign off = 2'(b) - base[1:0];
    assign idx = base + {{(PT_AW-2){1'b0}}, off};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (s2_valid && (s2_req == REQ_POINT) && (s2_pidx[1:0] == 2'(b))) begin
          mem[s2_pidx[PT_AW-1:2]] <= s2_pos;
        end
        rd[b] <= mem[idx[PT_AW-1:2]];
      end
    end
  end

  assign ev = '{valid: s3_valid, blo: s3_blo, t: s3_t, v2: s3_v2, v3: s3_v3, bank: rd};

endmodule
`default_nettype wire

### rtl/bsp_back.sv
`default_nettype none
module bsp_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bsp_pkg::eval_t ev,
  output logic adv,
  output logic res_valid,
  input  wire logic res_stall,
  output logic [1:0] component,
  output logic signed [39:0] value,
  output logic signed [39:0] first_deriv,
  output logic signed [39:0] second_deriv,
  output logic signed [39:0] third_deriv,
  output logic last
);
  import bsp_pkg::*;

  localparam logic signed [21:0] S1 = 22'sd65536;
  localparam logic signed [53:0] RND6 = 54'sd196608;
  localparam logic signed [53:0] RND1 = 54'sd32768;

  logic en;
  logic [1:0] cnt;

  logic signed [21:0] st, sv2, sv3;
  logic signed [21:0] wc [3][4];
  logic signed [31:0] pc [4];

  logic m1_valid;
  logic [1:0] m1_comp;
  logic signed [19:0] w [3][4];
  logic signed [31:0] p [4];

  logic m2_valid;
  logic [1:0] m2_comp;
  logic signed [51:0] prod [3][4];
  logic signed [34:0] m2_third;

  logic signed [53:0] acc [3];
  logic signed [53:0] ha, hd;

  logic m3_valid;
  logic [1:0] m3_comp;
  logic [35:0] ua, ud;
  logic signed [39:0] m3_sec;
  logic signed [34:0] m3_third;

  logic m4_valid;
  logic [1:0] m4_comp;
  logic [35:0] pa [4];
  logic [35:0] pd [4];
  logic signed [39:0] m4_sec;
  logic signed [34:0] m4_third;

  logic [71:0] fa, fd;

  assign en = !res_valid || !res_stall;
  assign adv = en && (!ev.valid || (cnt == COMP_R));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (en && ev.valid) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_comb begin
    st = {6'd0, ev.t};
    sv2 = {6'd0, ev.v2};
    sv3 = {6'd0, ev.v3};
    wc[0][0] = -sv3 + 22'sd3 * sv2 - 22'sd3 * st + S1;
    wc[0][1] = 22'sd3 * sv3 - 22'sd6 * sv2 + 22'sd4 * S1;
    wc[0][2] = -22'sd3 * sv3 + 22'sd3 * sv2 + 22'sd3 * st + S1;
    wc[0][3] = sv3;
    wc[1][0] = -22'sd3 * sv2 + 22'sd6 * st - 22'sd3 * S1;
    wc[1][1] = 22'sd9 * sv2 - 22'sd12 * st;
    wc[1][2] = -22'sd9 * sv2 + 22'sd6 * st + 22'sd3 * S1;
    wc[1][3] = 22'sd3 * sv2;
    wc[2][0] = S1 - st;
    wc[2][1] = 22'sd3 * st - 22'sd2 * S1;
    wc[2][2] = S1 - 22'sd3 * st;
    wc[2][3] = st;
    for (int k = 0; k < 4; k++) begin
      pc[k] = ev.bank[2'(ev.blo + 2'(k))][cnt*32 +: 32];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = 54'(prod[j][0]) + 54'(prod[j][1]) + 54'(prod[j][2]) + 54'(prod[j][3]);
    end
    ha = ((acc[0] + RND6) >>> 17) + DIV_OFS;
    hd = ((acc[1] + RND6) >>> 17) + DIV_OFS;
  end

  assign fa = {pa[3], 36'd0} + {18'd0, pa[2], 18'd0} + {18'd0, pa[1], 18'd0} + {36'd0, pa[0]};
  assign fd = {pd[3], 36'd0} + {18'd0, pd[2], 18'd0} + {18'd0, pd[1], 18'd0} + {36'd0, pd[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= ev.valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      res_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_comp <= cnt;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 4; k++) begin
          w[j][k] <= 20'(wc[j][k]);
        end
      end
      for (int k = 0; k < 4; k++) begin
        p[k] <= pc[k];
      end

      m2_comp <= m1_comp;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 4; k++) begin
          prod[j][k] <= w[j][k] * p[k];
        end
      end
      m2_third <= -35'(p[0]) + 35'sd3 * 35'(p[1]) - 35'sd3 * 35'(p[2]) + 35'(p[3]);

      m3_comp <= m2_comp;
      ua <= ha[35:0];
      ud <= hd[35:0];
      m3_sec <= 40'((acc[2] + RND1) >>> 16);
      m3_third <= m2_third;

      m4_comp <= m3_comp;
      pa[0] <= ua[17:0] * DIV3_MUL[17:0];
      pa[1] <= ua[35:18] * DIV3_MUL[17:0];
      pa[2] <= ua[17:0] * DIV3_MUL[35:18];
      pa[3] <= ua[35:18] * DIV3_MUL[35:18];
      pd[0] <= ud[17:0] * DIV3_MUL[17:0];
      pd[1] <= ud[35:18] * DIV3_MUL[17:0];
      pd[2] <= ud[17:0] * DIV3_MUL[35:18];
      pd[3] <= ud[35:18] * DIV3_MUL[35:18];
      m4_sec <= m3_sec;
      m4_third <= m3_third;

      component <= m4_comp;
      last <= (m4_comp == COMP_R);
      value <= {5'd0, fa[71:37]} - DIV_UNOFS;
      first_deriv <= {5'd0, fd[71:37]} - DIV_UNOFS;
      second_deriv <= m4_sec;
      third_deriv <= 40'(m4_third);
    end
  end

  a_last_radius: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (component == COMP_R)))
    else $error("last flag out of step with component");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !ev.valid |-> (cnt == 2'd0))
    else $error("component counter moved without an evaluation");

  a_comp_seq: assert property (@(posedge clk) disable iff (rst)
    (m1_valid && en && (m1_comp != COMP_R)) |=>
      (m1_valid && (m1_comp == 2'($past(m1_comp) + 2'd1))))
    else $error("component sequence broken");

endmodule
`default_nettype wire

### rtl/cubic_bspline_segment_eval.sv
`default_nettype none
// Uniform cubic B-spline evaluator. Type 0 words load a control point (x, y, z, radius),
// type 1 words load a segment start index, type 2 words evaluate a segment at v and
// return four words (x, y, z, radius, last set on radius) with value, first, second and
// third derivative; type 3 is dropped. Words are taken one per cycle while no evaluation
// is being expanded and the output is not stalled; an evaluate word occupies the shared
// multiplier set once per component, so a new evaluation is taken only after all four
// components of the last one have issued. The point store is four banks split on the
// index low bits, so all four points of a segment come out in one read. A first result
// passes s1 to s3, m1 to m4 and the output registers; the other three components follow.
module cubic_bspline_segment_eval (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_stall,
  input  wire logic [1:0] req_type,
  input  wire logic [9:0] point_index,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] radius_in,
  input  wire logic [9:0] seg_sel,
  input  wire logic [9:0] first_point,
  input  wire logic [15:0] v_local,
  output logic res_valid,
  input  wire logic res_stall,
  output logic [1:0] component,
  output logic signed [39:0] value,
  output logic signed [39:0] first_deriv,
  output logic signed [39:0] second_deriv,
  output logic signed [39:0] third_deriv,
  output logic last
);
  import bsp_pkg::*;

  eval_t ev;
  logic adv;

  assign req_stall = !adv;

  bsp_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .req_valid(req_valid), .req_type(req_type),
    .point_index(point_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .radius_in(radius_in), .seg_sel(seg_sel), .first_point(first_point),
    .v_local(v_local), .ev(ev)
  );

  bsp_back u_back (
    .clk(clk), .rst(rst), .ev(ev), .adv(adv), .res_valid(res_valid),
    .res_stall(res_stall), .component(component), .value(value),
    .first_deriv(first_deriv), .second_deriv(second_deriv),
    .third_deriv(third_deriv), .last(last)
  );

endmodule
`default_nettype wire

### sim/cubic_bspline_segment_eval_tb.sv
`timescale 1ns / 100ps
module cubic_bspline_segment_eval_tb;
  import bsp_pkg::*;

  typedef struct packed {
    logic [1:0] rtype;
    logic [9:0] pidx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] pr;
    logic [9:0] seg;
    logic [9:0] first;
    logic [15:0] v;
  } req_word_t;

  typedef struct packed {
    logic [1:0] comp;
    logic [39:0] val;
    logic [39:0] d1;
    logic [39:0] d2;
    logic [39:0] d3;
    logic lst;
  } curve_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] req_type = '0;
  logic [9:0] point_index = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic signed [31:0] radius_in = '0;
  logic [9:0] seg_sel = '0;
  logic [9:0] first_point = '0;
  logic [15:0] v_local = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [1:0] component;
  logic signed [39:0] value;
  logic signed [39:0] first_deriv;
  logic signed [39:0] second_deriv;
  logic signed [39:0] third_deriv;
  logic last;

  cubic_bspline_segment_eval u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  req_word_t pending_q[$];
  curve_word_t curve_q[$];
  logic [31:0] pt_mem[1024][4];
  logic [9:0] seg_mem[1024];
  bit pt_written[1024];
  bit seg_written[1024];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [39:0] sat40(input logic signed [63:0] x);
    if (x > 64'sd549755813887) return 40'h7F_FFFF_FFFF;
    if (x < -64'sd549755813888) return 40'h80_0000_0000;
    return x[39:0];
  endfunction

  function automatic logic signed [63:0] fdiv(input logic signed [63:0] n,
                                             input logic signed [63:0] d);
    logic signed [63:0] q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  task automatic predict_curve(input req_word_t w);
    logic signed [63:0] t, s, v2, v3, aa, ad, ae, th;
    logic signed [63:0] wa[4], wd[4], we[4], p[4];
    curve_word_t r;
    case (w.rtype)
      REQ_POINT: begin
        pt_mem[w.pidx] = '{w.px, w.py, w.pz, w.pr};
        pt_written[w.pidx] = 1;
      end
      REQ_SEG: begin
        seg_mem[w.seg] = w.first;
        seg_written[w.seg] = 1;
      end
      REQ_EVAL: begin
        s = 64'sd65536;
        t = w.v;
        v2 = (t * t) >>> 16;
        v3 = (v2 * t) >>> 16;
        wa = '{-v3 + 3*v2 - 3*t + s, 3*v3 - 6*v2 + 4*s, -3*v3 + 3*v2 + 3*t + s, v3};
        wd = '{-3*v2 + 6*t - 3*s, 9*v2 - 12*t, -9*v2 + 6*t + 3*s, 3*v2};
        we = '{s - t, 3*t - 2*s, s - 3*t, t};
        for (int c = 0; c < 4; c++) begin
          aa = 0; ad = 0; ae = 0;
          for (int k = 0; k < 4; k++) begin
            p[k] = $signed(pt_mem[(seg_mem[w.seg] + k) % 1024][c]);
            aa += wa[k] * p[k];
            ad += wd[k] * p[k];
            ae += we[k] * p[k];
          end
          th = -p[0] + 3*p[1] - 3*p[2] + p[3];
          r.comp = c[1:0];
          r.val = sat40(fdiv(aa + 3*s, 6*s));
          r.d1 = sat40(fdiv(ad + 3*s, 6*s));
          r.d2 = sat40(fdiv(ae + s/2, s));
          r.d3 = sat40(th);
          r.lst = (c[1:0] == COMP_R);
          curve_q = {curve_q, r};
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_curve(
        '{req_type, point_index, pos_x, pos_y, pos_z, radius_in, seg_sel, first_point,
          v_local});
      if (!req_valid || !req_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_word_t w;
          w = pending_q.pop_front();
          req_valid <= 1'b1;
          req_type <= w.rtype;
          point_index <= w.pidx;
          pos_x <= w.px;
          pos_y <= w.py;
          pos_z <= w.pz;
          radius_in <= w.pr;
          seg_sel <= w.seg;
          first_point <= w.first;
          v_local <= w.v;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (res_valid && !res_stall) begin
      if (curve_q.size() == 0) begin
        report("unexpected word", {38'd0, component}, 40'd0);
      end else begin
        curve_word_t e;
        e = curve_q.pop_front();
        if (component !== e.comp) report("component", {38'd0, component}, {38'd0, e.comp});
        if (value !== e.val) report("value", value, e.val);
        if (first_deriv !== e.d1) report("first_deriv", first_deriv, e.d1);
        if (second_deriv !== e.d2) report("second_deriv", second_deriv, e.d2);
        if (third_deriv !== e.d3) report("third_deriv", third_deriv, e.d3);
        if (last !== e.lst) report("last", {39'd0, last}, {39'd0, e.lst});
      end
    end
    res_stall <= rst ? 1'b0 : (hold_off || ($urandom_range(99) < recv_stall));
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_word_t rand_word(input logic [1:0] rt);
    req_word_t w;
    w.rtype = rt;
    w.pidx = 10'($urandom);
    w.px = rand_coord();
    w.py = rand_coord();
    w.pz = rand_coord();
    w.pr = rand_coord();
    w.seg = 10'($urandom);
    w.first = 10'($urandom);
    w.v = 16'($urandom);
    return w;
  endfunction

  task automatic enqueue(input req_word_t w);
    pending_q = {pending_q, w};
  endtask

  task automatic add_point(input logic [9:0] i);
    req_word_t w;
    w = rand_word(REQ_POINT);
    w.pidx = i;
    enqueue(w);
  endtask

  task automatic add_segment(input logic [9:0] sg, input logic [9:0] fp);
    req_word_t w;
    w = rand_word(REQ_SEG);
    w.seg = sg;
    w.first = fp;
    enqueue(w);
  endtask

  task automatic add_eval(input logic [9:0] sg, input logic [15:0] v);
    req_word_t w;
    w = rand_word(REQ_EVAL);
    w.seg = sg;
    w.v = v;
    enqueue(w);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || req_valid || curve_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    req_word_t w;
    logic [9:0] sg, fp;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extreme points, wrap at store end, extreme v, ignored words
    for (int i = 0; i < 4; i++) begin
      w = rand_word(REQ_POINT);
      w.pidx = 10'(i);
      w.px = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      w.py = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      w.pz = 32'h7FFF_FFFF;
      w.pr = 32'h8000_0000;
      enqueue(w);
    end
    add_point(10'd1022);
    add_point(10'd1023);
    add_segment(10'd0, 10'd0);
    add_segment(10'd1023, 10'd1022);
    add_eval(10'd0, 16'd0);
    add_eval(10'd0, 16'hFFFF);
    add_eval(10'd0, 16'h8000);
    add_eval(10'd1023, 16'd1);
    add_eval(10'd1023, 16'hFFFF);
    enqueue(rand_word(REQ_NONE));
    add_eval(10'd0, 16'h4000);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 24 : 48) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 24 : 48) : 0;
      for (n = 0; n < 16; n++) begin
        case ($urandom_range(9))
          0, 1: add_point(10'($urandom));
          2: begin
            fp = 10'($urandom);
            if (pt_written[fp] && pt_written[(fp + 1) % 1024] &&
                pt_written[(fp + 2) % 1024] && pt_written[(fp + 3) % 1024])
              add_segment(10'($urandom), fp);
            else begin
              for (int k = 0; k < 4; k++) add_point(10'(fp + k));
              add_segment(10'($urandom), fp);
            end
          end
          3: enqueue(rand_word(REQ_NONE));
          default: begin
            sg = 10'($urandom);
            if (!seg_written[sg]) begin
              fp = 10'($urandom);
              for (int k = 0; k < 4; k++) add_point(10'(fp + k));
              add_segment(sg, fp);
            end
            add_eval(sg, 16'($urandom));
          end
        endcase
        // keep the written flags current with what is queued
        foreach (pending_q[j]) begin
          if (pending_q[j].rtype == REQ_POINT) pt_written[pending_q[j].pidx] = 1;
          if (pending_q[j].rtype == REQ_SEG) seg_written[pending_q[j].seg] = 1;
        end
      end
      if (ph == 0) begin
        repeat (10) @(posedge clk);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (stim_done) begin
      if (errors == 0)
        $display("All tests passed");
      else
        $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
